>>> rtl/rvcore_pkg.sv
// shared types and constants for the rv64i subset core
// no dependencies

package rvcore_pkg;

  localparam int XLEN     = 64;
  localparam int PC_W     = 16;
  localparam int RF_DEPTH = 32;

  // item kinds
  localparam logic ITEM_WRITE = 1'b0;
  localparam logic ITEM_EXEC  = 1'b1;

  // configuration register indexes
  localparam logic CFG_ENTRY = 1'b0;
  localparam logic CFG_STACK = 1'b1;

  localparam logic [PC_W-1:0] ENTRY_RESET = 16'h0000;
  localparam logic [PC_W-1:0] STACK_RESET = 16'hfff0;

  // major opcodes
  localparam logic [6:0] OPC_OP     = 7'h33;
  localparam logic [6:0] OPC_OPIMM  = 7'h13;
  localparam logic [6:0] OPC_LOAD   = 7'h03;
  localparam logic [6:0] OPC_STORE  = 7'h23;
  localparam logic [6:0] OPC_LUI    = 7'h37;
  localparam logic [6:0] OPC_AUIPC  = 7'h17;
  localparam logic [6:0] OPC_JAL    = 7'h6f;
  localparam logic [6:0] OPC_JALR   = 7'h67;
  localparam logic [6:0] OPC_BRANCH = 7'h63;
  localparam logic [6:0] OPC_SYSTEM = 7'h73;

  localparam logic [6:0] F7_BASE = 7'h00;
  localparam logic [6:0] F7_ALT  = 7'h20;
  localparam logic [5:0] F6_BASE = 6'h00;
  localparam logic [5:0] F6_ALT  = 6'h10;

  localparam logic [4:0] REG_ZERO = 5'd0;
  localparam logic [4:0] REG_SP   = 5'd2;
  localparam logic [4:0] REG_A7   = 5'd17;

  localparam logic [XLEN-1:0] SYS_EXIT       = 64'd93;
  localparam logic [XLEN-1:0] SYS_EXIT_GROUP = 64'd94;

  typedef struct packed {
    logic        op;
    logic [15:0] addr;
    logic [7:0]  data;
  } item_t;

  typedef struct packed {
    logic [PC_W-1:0] pc_after;
    logic [31:0]     word;
    logic            wr;
    logic [4:0]      idx;
    logic [XLEN-1:0] val;
    logic            halted;
  } result_t;

endpackage

>>> rtl/rvcore_ram.sv
// generic single-write, single-read ram with registered read data
// no dependencies

module rvcore_ram #(
  parameter int WIDTH = 8,
  parameter int DEPTH = 16,
  localparam int AW = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             we,
  input  logic [AW-1:0]    waddr,
  input  logic [WIDTH-1:0] wdata,
  input  logic [AW-1:0]    raddr,
  output logic [WIDTH-1:0] rdata
);

  logic [WIDTH-1:0] mem [DEPTH];
  logic [WIDTH-1:0] rdata_r;

  always_ff @(posedge clk) begin
    if (we) begin
      mem[waddr] <= wdata;
    end
    rdata_r <= mem[raddr];
  end

  assign rdata = rdata_r;

endmodule

>>> rtl/rvcore_front.sv
// front end: accepts items and queues them for the execution back end
// depends on rvcore_pkg

module rvcore_front
  import rvcore_pkg::*;
(
  input  logic        clk,
  input  logic        rst_n,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [15:0] in_load_address,
  input  logic [7:0]  in_load_byte,
  output logic        q_valid,
  output item_t       q_item,
  input  logic        q_pop
);

  item_t       slot_r [2];
  logic        wp_r, wp_nxt;
  logic        rp_r, rp_nxt;
  logic [1:0]  cnt_r, cnt_nxt;
  logic        push;
  item_t       in_item;

  assign in_ready = (cnt_r != 2'd2);
  assign push     = in_valid && in_ready;
  assign q_valid  = (cnt_r != 2'd0);
  assign q_item   = slot_r[rp_r];

  // loader writes and instruction steps are tagged here and kept in order
  always_comb begin
    in_item.op   = in_op ? ITEM_EXEC : ITEM_WRITE;
    in_item.addr = in_load_address;
    in_item.data = in_load_byte;
  end

  always_comb begin
    wp_nxt  = wp_r ^ push;
    rp_nxt  = rp_r ^ q_pop;
    cnt_nxt = cnt_r + {1'b0, push} - {1'b0, q_pop};
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wp_r  <= 1'b0;
      rp_r  <= 1'b0;
      cnt_r <= 2'd0;
    end else begin
      wp_r  <= wp_nxt;
      rp_r  <= rp_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    if (push) begin
      slot_r[wp_r] <= in_item;
    end
  end

endmodule

>>> rtl/rvcore_back.sv
// back end: sequencer, register file, byte memory banks and execute logic
// depends on rvcore_pkg and rvcore_ram

module rvcore_back
  import rvcore_pkg::*;
#(
  parameter int MEM_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        q_valid,
  input  item_t       q_item,
  output logic        q_pop,
  output logic        out_valid,
  input  logic        out_ready,
  output result_t     out_res
);

  localparam int AW   = $clog2(MEM_BYTES);
  localparam int RW   = AW - 2;
  localparam int ROWS = MEM_BYTES / 4;

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_FETCH = 3'd2;
  localparam logic [2:0] S_EXEC  = 3'd3;
  localparam logic [2:0] S_LOAD  = 3'd4;
  localparam logic [2:0] S_DONE  = 3'd5;

  logic [2:0]        state_r, state_nxt;
  logic [RW-1:0]     clr_r;
  logic [PC_W-1:0]   pc_r;
  logic [XLEN-1:0]   sp_r;
  logic              run_r;
  logic [RF_DEPTH-1:0] rf_vld_r;
  logic [31:0]       word_r;
  logic [4:0]        ra1_r, ra2_r;
  logic [1:0]        lo_r;
  logic              res_wr_r;
  logic [4:0]        res_idx_r;
  logic [XLEN-1:0]   res_val_r;
  logic [31:0]       res_word_r;
  logic              out_vld_r;
  result_t           out_r;

  // memory banks, byte address a lives in bank a[1:0], row a[AW-1:2]
  logic          bk_we    [4];
  logic [RW-1:0] bk_waddr [4];
  logic [7:0]    bk_wdata [4];
  logic [RW-1:0] bk_raddr [4];
  logic [7:0]    bk_rdata [4];

  for (genvar g = 0; g < 4; g++) begin : g_bank
    rvcore_ram #(.WIDTH(8), .DEPTH(ROWS)) u_bank (
      .clk  (clk),
      .we   (bk_we[g]),
      .waddr(bk_waddr[g]),
      .wdata(bk_wdata[g]),
      .raddr(bk_raddr[g]),
      .rdata(bk_rdata[g])
    );
  end

  // register file: two copies for two read ports, x0 and x2 live outside
  logic            rf_we;
  logic [4:0]      rf_ra1, rf_ra2;
  logic [XLEN-1:0] rf_rd1, rf_rd2;
  logic [4:0]      wb_idx;
  logic [XLEN-1:0] wb_val;
  logic            wb_en;

  rvcore_ram #(.WIDTH(XLEN), .DEPTH(RF_DEPTH)) u_rf1 (
    .clk(clk), .we(rf_we), .waddr(wb_idx), .wdata(wb_val), .raddr(rf_ra1), .rdata(rf_rd1)
  );
  rvcore_ram #(.WIDTH(XLEN), .DEPTH(RF_DEPTH)) u_rf2 (
    .clk(clk), .we(rf_we), .waddr(wb_idx), .wdata(wb_val), .raddr(rf_ra2), .rdata(rf_rd2)
  );

  // address forms
  logic [AW+PC_W-1:0] pc_ext, la_ext;
  logic [AW-1:0]      pc_a, la_a, ea_a, sa_a, rd_base;
  logic [31:0]        asm_w;
  logic [6:0]         opc, f7;
  logic [2:0]         f3;
  logic [4:0]         rd;
  logic [XLEN-1:0]    a, b;
  logic [XLEN-1:0]    immi, imms, immb, immj, immu;
  logic [XLEN-1:0]    ea, sa, pc64;
  logic [5:0]         sh;
  logic [XLEN-1:0]    opb;
  logic               ex_wr, ex_load, ex_store, ex_halt, wr_eff;
  logic [XLEN-1:0]    ex_val;
  logic [PC_W-1:0]    ex_next;
  logic               br_take, br_ok;
  logic [XLEN-1:0]    ld_val;
  logic               out_free;
  logic               out_take;

  assign pc_ext = {{AW{1'b0}}, pc_r};
  assign pc_a   = pc_ext[AW-1:0];
  assign la_ext = {{AW{1'b0}}, q_item.addr};
  assign la_a   = la_ext[AW-1:0];

  // assemble four bytes starting at the registered low address bits
  always_comb begin
    for (int k = 0; k < 4; k++) begin
      asm_w[8*k +: 8] = bk_rdata[2'(lo_r + 2'(k))];
    end
  end

  assign opc = word_r[6:0];
  assign f3  = word_r[14:12];
  assign f7  = word_r[31:25];
  assign rd  = word_r[11:7];

  // operand read, x0 is zero, x2 comes from its own register
  always_comb begin
    if (ra1_r == REG_ZERO) a = '0;
    else if (ra1_r == REG_SP) a = sp_r;
    else if (rf_vld_r[ra1_r]) a = rf_rd1;
    else a = '0;
    if (ra2_r == REG_ZERO) b = '0;
    else if (ra2_r == REG_SP) b = sp_r;
    else if (rf_vld_r[ra2_r]) b = rf_rd2;
    else b = '0;
  end

  assign immi = {{52{word_r[31]}}, word_r[31:20]};
  assign imms = {{52{word_r[31]}}, word_r[31:25], word_r[11:7]};
  assign immb = {{51{word_r[31]}}, word_r[31], word_r[7], word_r[30:25], word_r[11:8], 1'b0};
  assign immj = {{43{word_r[31]}}, word_r[31], word_r[19:12], word_r[20], word_r[30:21],
                 1'b0};
  assign immu = {{32{word_r[31]}}, word_r[31:12], 12'b0};
  assign ea   = a + immi;
  assign sa   = a + imms;
  assign ea_a = ea[AW-1:0];
  assign sa_a = sa[AW-1:0];
  assign pc64 = {{(XLEN-PC_W){1'b0}}, pc_r};

  always_comb begin
    opb = (opc == OPC_OP) ? b : immi;
    sh  = (opc == OPC_OP) ? b[5:0] : word_r[25:20];
  end

  // execute
  always_comb begin
    ex_wr    = 1'b0;
    ex_val   = '0;
    ex_load  = 1'b0;
    ex_store = 1'b0;
    ex_halt  = 1'b0;
    ex_next  = pc_r + 16'd4;
    br_take  = 1'b0;
    br_ok    = 1'b1;
    case (opc)
      OPC_OP, OPC_OPIMM: begin
        ex_wr = 1'b1;
        case (f3)
          3'd0: begin
            if (opc == OPC_OPIMM) ex_val = a + opb;
            else if (f7 == F7_BASE) ex_val = a + opb;
            else if (f7 == F7_ALT) ex_val = a - opb;
            else ex_wr = 1'b0;
          end
          3'd1: begin
            ex_val = a << sh;
            if (opc == OPC_OP && f7 != F7_BASE) ex_wr = 1'b0;
            if (opc == OPC_OPIMM && word_r[31:26] != F6_BASE) ex_wr = 1'b0;
          end
          3'd2: ex_val = {63'b0, $signed(a) < $signed(opb)};
          3'd3: ex_val = {63'b0, a < opb};
          3'd4: ex_val = a ^ opb;
          3'd5: begin
            if ((opc == OPC_OP && f7 == F7_BASE) ||
                (opc == OPC_OPIMM && word_r[31:26] == F6_BASE)) begin
              ex_val = a >> sh;
            end else if ((opc == OPC_OP && f7 == F7_ALT) ||
                         (opc == OPC_OPIMM && word_r[31:26] == F6_ALT)) begin
              ex_val = $unsigned($signed(a) >>> sh);
            end else begin
              ex_wr = 1'b0;
            end
          end
          3'd6: ex_val = a | opb;
          default: ex_val = a & opb;
        endcase
        if (opc == OPC_OP && f3 != 3'd0 && f3 != 3'd5 && f7 != F7_BASE) ex_wr = 1'b0;
      end
      OPC_LOAD: begin
        ex_load = (f3 == 3'd0) || (f3 == 3'd1) || (f3 == 3'd2) || (f3 == 3'd4) ||
                  (f3 == 3'd5);
        ex_wr   = ex_load;
      end
      OPC_STORE: ex_store = (f3 == 3'd0) || (f3 == 3'd1) || (f3 == 3'd2);
      OPC_LUI: begin
        ex_wr  = 1'b1;
        ex_val = immu;
      end
      OPC_AUIPC: begin
        ex_wr  = 1'b1;
        ex_val = pc64 + immu;
      end
      OPC_JAL: begin
        ex_wr   = 1'b1;
        ex_val  = pc64 + 64'd4;
        ex_next = pc_r + immj[PC_W-1:0];
      end
      OPC_JALR: begin
        if (f3 == 3'd0) begin
          ex_wr   = 1'b1;
          ex_val  = pc64 + 64'd4;
          ex_next = {ea[PC_W-1:1], 1'b0};
        end
      end
      OPC_BRANCH: begin
        case (f3)
          3'd0: br_take = (a == b);
          3'd1: br_take = (a != b);
          3'd4: br_take = $signed(a) < $signed(b);
          3'd5: br_take = !($signed(a) < $signed(b));
          3'd6: br_take = a < b;
          3'd7: br_take = a >= b;
          default: br_ok = 1'b0;
        endcase
        if (br_ok && br_take) ex_next = pc_r + immb[PC_W-1:0];
      end
      OPC_SYSTEM: begin
        // rs1 port was steered to a7 for this opcode
        if (f3 == 3'd0 && word_r[31:20] == 12'd0 && word_r[19:15] == REG_ZERO &&
            rd == REG_ZERO && (a == SYS_EXIT || a == SYS_EXIT_GROUP)) begin
          ex_halt = 1'b1;
        end
      end
      default: ;
    endcase
  end

  assign wr_eff = ex_wr && (rd != REG_ZERO);

  always_comb begin
    case (f3)
      3'd0: ld_val = {{56{asm_w[7]}}, asm_w[7:0]};
      3'd1: ld_val = {{48{asm_w[15]}}, asm_w[15:0]};
      3'd2: ld_val = {{32{asm_w[31]}}, asm_w};
      3'd4: ld_val = {56'b0, asm_w[7:0]};
      default: ld_val = {48'b0, asm_w[15:0]};
    endcase
  end

  // register write back
  always_comb begin
    wb_idx = rd;
    wb_en  = ((state_r == S_EXEC) && wr_eff && !ex_load) ||
             ((state_r == S_LOAD) && res_wr_r);
    wb_val = (state_r == S_LOAD) ? ld_val : ex_val;
    rf_we  = wb_en && (wb_idx != REG_SP);
  end

  // register file read addresses, taken from the freshly fetched word
  always_comb begin
    rf_ra1 = (asm_w[6:0] == OPC_SYSTEM) ? REG_A7 : asm_w[19:15];
    rf_ra2 = asm_w[24:20];
  end

  // bank ports
  always_comb begin
    logic [1:0]    off;
    logic [AW-1:0] ab;
    rd_base = (state_r == S_IDLE) ? pc_a : ea_a;
    for (int k = 0; k < 4; k++) begin
      off          = 2'(k) - rd_base[1:0];
      ab           = rd_base + {{(AW-2){1'b0}}, off};
      bk_raddr[k]  = ab[AW-1:2];
      bk_we[k]     = 1'b0;
      bk_waddr[k]  = clr_r;
      bk_wdata[k]  = 8'd0;
      if (state_r == S_CLEAR) begin
        bk_we[k] = 1'b1;
      end else if (state_r == S_IDLE && q_valid && q_item.op == ITEM_WRITE) begin
        bk_we[k]    = (la_a[1:0] == 2'(k));
        bk_waddr[k] = la_a[AW-1:2];
        bk_wdata[k] = q_item.data;
      end else if (state_r == S_EXEC && ex_store) begin
        off         = 2'(k) - sa_a[1:0];
        ab          = sa_a + {{(AW-2){1'b0}}, off};
        bk_we[k]    = ({1'b0, off} < (3'd1 << f3[1:0]));
        bk_waddr[k] = ab[AW-1:2];
        bk_wdata[k] = b[8*off +: 8];
      end
    end
  end

  assign out_free = !out_vld_r || out_ready;
  assign out_take = (state_r == S_DONE) && out_free;
  assign q_pop    = (state_r == S_IDLE) && q_valid;

  always_comb begin
    state_nxt = state_r;
    case (state_r)
      S_CLEAR: if (clr_r == {RW{1'b1}}) state_nxt = S_IDLE;
      S_IDLE: begin
        if (q_valid) begin
          if (q_item.op == ITEM_EXEC && run_r) state_nxt = S_FETCH;
          else state_nxt = S_DONE;
        end
      end
      S_FETCH: state_nxt = S_EXEC;
      S_EXEC:  state_nxt = ex_load ? S_LOAD : S_DONE;
      S_LOAD:  state_nxt = S_DONE;
      S_DONE:  if (out_free) state_nxt = S_IDLE;
      default: state_nxt = S_IDLE;
    endcase
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      state_r   <= S_CLEAR;
      clr_r     <= '0;
      pc_r      <= ENTRY_RESET;
      sp_r      <= {{(XLEN-PC_W){1'b0}}, STACK_RESET};
      run_r     <= 1'b1;
      rf_vld_r  <= '0;
      out_vld_r <= 1'b0;
    end else begin
      state_r <= state_nxt;
      if (state_r == S_CLEAR) clr_r <= clr_r + 1'b1;
      if (state_r == S_EXEC) begin
        pc_r <= ex_next;
        if (ex_halt) run_r <= 1'b0;
      end
      if (wb_en) begin
        rf_vld_r[wb_idx] <= 1'b1;
        if (wb_idx == REG_SP) sp_r <= wb_val;
      end
      if (out_take) out_vld_r <= 1'b1;
      else if (out_ready) out_vld_r <= 1'b0;
      if (cfg_we) begin
        if (cfg_index == CFG_ENTRY) pc_r <= cfg_data;
        else sp_r <= {{(XLEN-PC_W){1'b0}}, cfg_data};
      end
    end
  end

  always_ff @(posedge clk) begin
    case (state_r)
      S_IDLE: begin
        lo_r       <= pc_a[1:0];
        res_wr_r   <= 1'b0;
        res_idx_r  <= REG_ZERO;
        res_val_r  <= '0;
        res_word_r <= '0;
      end
      S_FETCH: begin
        word_r     <= asm_w;
        res_word_r <= asm_w;
        ra1_r      <= rf_ra1;
        ra2_r      <= rf_ra2;
      end
      S_EXEC: begin
        lo_r      <= ea_a[1:0];
        res_wr_r  <= wr_eff;
        res_idx_r <= wr_eff ? rd : REG_ZERO;
        res_val_r <= (wr_eff && !ex_load) ? ex_val : '0;
      end
      S_LOAD: begin
        if (res_wr_r) res_val_r <= ld_val;
      end
      default: ;
    endcase
    if (out_take) begin
      out_r.pc_after <= pc_r;
      out_r.word     <= res_word_r;
      out_r.wr       <= res_wr_r;
      out_r.idx      <= res_idx_r;
      out_r.val      <= res_val_r;
      out_r.halted   <= !run_r;
    end
  end

  assign out_valid = out_vld_r;
  assign out_res   = out_r;

`ifndef SYNTHESIS
  a_no_pop_in_clear: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_CLEAR) |-> !q_pop)
    else $error("queue popped during memory clear");
  a_pop_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
    q_pop |-> q_valid)
    else $error("pop from empty queue");
  a_no_x0_write: assert property (@(posedge clk) disable iff (!rst_n)
    wb_en |-> (wb_idx != REG_ZERO))
    else $error("write back to x0");
  a_halt_sticks: assert property (@(posedge clk) disable iff (!rst_n)
    !run_r |=> !run_r)
    else $error("core restarted without reset");
  a_result_hold: assert property (@(posedge clk) disable iff (!rst_n)
    (state_r == S_DONE && !out_free) |=> (state_r == S_DONE))
    else $error("result dropped while output busy");
`endif

endmodule

>>> rtl/rv64i_subset_core_step.sv
// the back end takes one queued item at a time and pops the next only once the last result
// has gone to the output register, which waits on out_ready; sequencer steps: fetch from
// byte banks, register file read, execute, load data for loads, result handoff
// reset: synchronous active-low; then a clearing pass over all MEM_BYTES/4 bank rows zeroes
// memory before any item executes; items queue meanwhile, config writes always taken
// depends on rvcore_pkg, rvcore_front, rvcore_back

module rv64i_subset_core_step
  import rvcore_pkg::*;
#(
  parameter int MEM_BYTES = 65536
) (
  input  logic        clk,
  input  logic        rst_n,
  input  logic        cfg_we,
  input  logic        cfg_index,
  input  logic [15:0] cfg_data,
  input  logic        in_valid,
  output logic        in_ready,
  input  logic        in_op,
  input  logic [15:0] in_load_address,
  input  logic [7:0]  in_load_byte,
  output logic        out_valid,
  input  logic        out_ready,
  output logic [15:0] out_pc_after,
  output logic [31:0] out_fetched_word,
  output logic        out_reg_written,
  output logic [4:0]  out_dest_index,
  output logic [63:0] out_dest_value,
  output logic        out_halted
);

  logic    q_valid;
  item_t   q_item;
  logic    q_pop;
  result_t res;

  rvcore_front u_front (
    .clk            (clk),
    .rst_n          (rst_n),
    .in_valid       (in_valid),
    .in_ready       (in_ready),
    .in_op          (in_op),
    .in_load_address(in_load_address),
    .in_load_byte   (in_load_byte),
    .q_valid        (q_valid),
    .q_item         (q_item),
    .q_pop          (q_pop)
  );

  rvcore_back #(.MEM_BYTES(MEM_BYTES)) u_back (
    .clk      (clk),
    .rst_n    (rst_n),
    .cfg_we   (cfg_we),
    .cfg_index(cfg_index),
    .cfg_data (cfg_data),
    .q_valid  (q_valid),
    .q_item   (q_item),
    .q_pop    (q_pop),
    .out_valid(out_valid),
    .out_ready(out_ready),
    .out_res  (res)
  );

  assign out_pc_after     = res.pc_after;
  assign out_fetched_word = res.word;
  assign out_reg_written  = res.wr;
  assign out_dest_index   = res.idx;
  assign out_dest_value   = res.val;
  assign out_halted       = res.halted;

endmodule

>>> bench/tb_rv64i_subset_core_step.sv
// testbench for rv64i_subset_core_step: random rv64i programs loaded byte by byte and run
// against a behavioral copy of the core, with random idling and backpressure
// depends on rvcore_pkg and the rv64i_subset_core_step rtl

module tb_rv64i_subset_core_step;
  import rvcore_pkg::*;
  timeunit 1ns;
  timeprecision 1ps;

  // funct3 codes
  localparam logic [2:0] F3_ADDSUB = 3'd0, F3_SLL = 3'd1, F3_SLT = 3'd2, F3_SLTU = 3'd3;
  localparam logic [2:0] F3_XOR = 3'd4, F3_SR = 3'd5, F3_OR = 3'd6, F3_AND = 3'd7;
  localparam logic [2:0] F3_B = 3'd0, F3_H = 3'd1, F3_W = 3'd2, F3_BU = 3'd4, F3_HU = 3'd5;
  localparam logic [2:0] F3_D = 3'd3;
  localparam logic [2:0] F3_BEQ = 3'd0, F3_BNE = 3'd1, F3_BLT = 3'd4, F3_BGE = 3'd5;
  localparam logic [2:0] F3_BLTU = 3'd6, F3_BGEU = 3'd7;
  localparam logic [2:0] F3_PRIV = 3'd0;

  logic        clk = 1'b0;
  logic        rst_n = 1'b0;
  logic        cfg_we = 1'b0;
  logic        cfg_index = CFG_ENTRY;
  logic [15:0] cfg_data = '0;
  logic        in_valid = 1'b0;
  logic        in_ready;
  logic        in_op = ITEM_WRITE;
  logic [15:0] in_load_address = '0;
  logic [7:0]  in_load_byte = '0;
  logic        out_valid;
  logic        out_ready = 1'b0;
  logic [15:0] out_pc_after;
  logic [31:0] out_fetched_word;
  logic        out_reg_written;
  logic [4:0]  out_dest_index;
  logic [63:0] out_dest_value;
  logic        out_halted;

  rv64i_subset_core_step i_dut (.*);

  // core state as seen from outside
  logic [63:0] gpr_copy [32];
  logic [15:0] pc_copy;
  logic [7:0]  mem_copy [65536];
  logic        running_copy;

  result_t pending_results[$];
  int      n_errors = 0;
  int      send_idle_pct = 0;
  int      recv_idle_pct = 0;
  int      recv_hold = 0;

  initial forever #5 clk = ~clk;

  initial begin
    #5ms;
    $display("Testbench completed WITH ERRORS");
    $finish;
  end

  // receiver: random idling, or a counted hold-off
  always @(posedge clk) begin
    if (recv_hold > 0) begin
      out_ready <= 1'b0;
      recv_hold <= recv_hold - 1;
    end else begin
      out_ready <= ($urandom_range(99) >= recv_idle_pct);
    end
  end

  always @(posedge clk) begin
    result_t e;
    if (rst_n && out_valid && out_ready) begin
      if (pending_results.size() == 0) begin
        $error("result transaction with nothing expected");
        n_errors++;
      end else begin
        e = pending_results.pop_front();
        if (out_pc_after !== e.pc_after) begin
          $error("pc_after exp %h got %h", e.pc_after, out_pc_after); n_errors++;
        end
        if (out_fetched_word !== e.word) begin
          $error("fetched_word exp %h got %h", e.word, out_fetched_word); n_errors++;
        end
        if (out_reg_written !== e.wr) begin
          $error("reg_written exp %b got %b", e.wr, out_reg_written); n_errors++;
        end
        if (out_dest_index !== e.idx) begin
          $error("dest_index exp %0d got %0d", e.idx, out_dest_index); n_errors++;
        end
        if (out_dest_value !== e.val) begin
          $error("dest_value exp %h got %h", e.val, out_dest_value); n_errors++;
        end
        if (out_halted !== e.halted) begin
          $error("halted exp %b got %b", e.halted, out_halted); n_errors++;
        end
      end
    end
  end

  function automatic logic [63:0] mem_read(input logic [15:0] base, input int n);
    logic [63:0] v;
    v = '0;
    for (int k = 0; k < n; k++) v[8*k +: 8] = mem_copy[base + 16'(k)];
    return v;
  endfunction

  task automatic step_core(input logic op, input logic [15:0] la, input logic [7:0] lb,
                           output result_t r);
    logic [31:0] w;
    logic [15:0] pc, nxt, ad;
    logic [63:0] a, b, immi, imms, immb, immj, immu, v, t;
    logic [4:0]  rd;
    logic [6:0]  f7;
    logic [5:0]  f6, sh;
    logic [2:0]  f3;
    logic        wr, take, ok;
    w = '0; v = '0; rd = '0; wr = 1'b0;
    if (op == ITEM_WRITE) begin
      mem_copy[la] = lb;
    end else if (running_copy) begin
      pc = pc_copy;
      nxt = pc + 16'd4;
      w = 32'(mem_read(pc, 4));
      f3 = w[14:12]; f7 = w[31:25]; f6 = w[31:26]; sh = w[25:20];
      a = gpr_copy[w[19:15]];
      b = gpr_copy[w[24:20]];
      rd = w[11:7];
      immi = {{52{w[31]}}, w[31:20]};
      imms = {{52{w[31]}}, w[31:25], w[11:7]};
      immb = {{51{w[31]}}, w[31], w[7], w[30:25], w[11:8], 1'b0};
      immj = {{43{w[31]}}, w[31], w[19:12], w[20], w[30:21], 1'b0};
      immu = {{32{w[31]}}, w[31:12], 12'b0};
      case (w[6:0])
        OPC_OP: begin
          wr = 1'b1;
          if (f7 == F7_BASE) begin
            case (f3)
              F3_ADDSUB: v = a + b;
              F3_SLL:    v = a << b[5:0];
              F3_SLT:    v = 64'($signed(a) < $signed(b));
              F3_SLTU:   v = 64'(a < b);
              F3_XOR:    v = a ^ b;
              F3_SR:     v = a >> b[5:0];
              F3_OR:     v = a | b;
              default:   v = a & b;
            endcase
          end else if (f7 == F7_ALT && f3 == F3_ADDSUB) v = a - b;
          else if (f7 == F7_ALT && f3 == F3_SR) v = $signed(a) >>> b[5:0];
          else wr = 1'b0;
        end
        OPC_OPIMM: begin
          wr = 1'b1;
          case (f3)
            F3_ADDSUB: v = a + immi;
            F3_SLL: if (f6 == F6_BASE) v = a << sh; else wr = 1'b0;
            F3_SLT:  v = 64'($signed(a) < $signed(immi));
            F3_SLTU: v = 64'(a < immi);
            F3_XOR:  v = a ^ immi;
            F3_SR: begin
              if (f6 == F6_BASE) v = a >> sh;
              else if (f6 == F6_ALT) v = $signed(a) >>> sh;
              else wr = 1'b0;
            end
            F3_OR:   v = a | immi;
            default: v = a & immi;
          endcase
        end
        OPC_LOAD: begin
          t = a + immi;
          ad = t[15:0];
          wr = 1'b1;
          case (f3)
            F3_B: begin t = mem_read(ad, 1); v = {{56{t[7]}}, t[7:0]}; end
            F3_H: begin t = mem_read(ad, 2); v = {{48{t[15]}}, t[15:0]}; end
            F3_W: begin t = mem_read(ad, 4); v = {{32{t[31]}}, t[31:0]}; end
            F3_BU: v = mem_read(ad, 1);
            F3_HU: v = mem_read(ad, 2);
            default: wr = 1'b0;
          endcase
        end
        OPC_STORE: begin
          t = a + imms;
          ad = t[15:0];
          if (f3 <= F3_W)
            for (int k = 0; k < (1 << f3); k++) mem_copy[ad + 16'(k)] = b[8*k +: 8];
        end
        OPC_LUI: begin wr = 1'b1; v = immu; end
        OPC_AUIPC: begin wr = 1'b1; v = {48'b0, pc} + immu; end
        OPC_JAL: begin
          wr = 1'b1;
          v = {48'b0, pc} + 64'd4;
          nxt = pc + immj[15:0];
        end
        OPC_JALR: begin
          if (f3 == F3_PRIV) begin
            wr = 1'b1;
            v = {48'b0, pc} + 64'd4;
            t = a + immi;
            nxt = {t[15:1], 1'b0};
          end
        end
        OPC_BRANCH: begin
          ok = 1'b1; take = 1'b0;
          case (f3)
            F3_BEQ:  take = (a == b);
            F3_BNE:  take = (a != b);
            F3_BLT:  take = $signed(a) < $signed(b);
            F3_BGE:  take = !($signed(a) < $signed(b));
            F3_BLTU: take = a < b;
            F3_BGEU: take = a >= b;
            default: ok = 1'b0;
          endcase
          if (ok && take) nxt = pc + immb[15:0];
        end
        OPC_SYSTEM: begin
          if (f3 == F3_PRIV && w[31:20] == 12'd0 && w[19:15] == REG_ZERO && rd == REG_ZERO)
            if (gpr_copy[REG_A7] == SYS_EXIT || gpr_copy[REG_A7] == SYS_EXIT_GROUP)
              running_copy = 1'b0;
        end
        default: ;
      endcase
      if (wr && rd != REG_ZERO) gpr_copy[rd] = v;
      else begin wr = 1'b0; rd = '0; v = '0; end
      pc_copy = nxt;
    end
    r.pc_after = pc_copy;
    r.word = w;
    r.wr = wr;
    r.idx = rd;
    r.val = v;
    r.halted = !running_copy;
  endtask

  task automatic send_item(input logic op, input logic [15:0] la, input logic [7:0] lb);
    result_t r;
    if ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
      while ($urandom_range(99) < send_idle_pct) @(posedge clk);
    end
    in_valid <= 1'b1;
    in_op <= op;
    in_load_address <= la;
    in_load_byte <= lb;
    @(posedge clk);
    while (!in_ready) @(posedge clk);
    step_core(op, la, lb, r);
    pending_results.push_back(r);
  endtask

  task automatic load_word(input logic [15:0] addr, input logic [31:0] w);
    for (int k = 0; k < 4; k++) send_item(ITEM_WRITE, addr + 16'(k), w[8*k +: 8]);
  endtask

  task automatic run_steps(input int n);
    repeat (n) send_item(ITEM_EXEC, 16'($urandom), 8'($urandom));
  endtask

  // drop valid and wait until the core has drained
  task automatic drain_core();
    in_valid <= 1'b0;
    @(posedge clk);
    while (pending_results.size() != 0) @(posedge clk);
    repeat (12) @(posedge clk);
  endtask

  task automatic write_cfg(input logic idx, input logic [15:0] data);
    drain_core();
    cfg_we <= 1'b1;
    cfg_index <= idx;
    cfg_data <= data;
    @(posedge clk);
    cfg_we <= 1'b0;
    if (idx == CFG_ENTRY) pc_copy = data;
    else gpr_copy[REG_SP] = {48'b0, data};
  endtask

  function automatic logic [31:0] enc_i(logic [11:0] imm, logic [4:0] rs1, logic [2:0] f3,
                                        logic [4:0] rd, logic [6:0] opc);
    return {imm, rs1, f3, rd, opc};
  endfunction

  // destination never a7, so ecalls in random programs do not stop the core
  function automatic logic [4:0] pick_rd();
    logic [4:0] r;
    r = 5'($urandom_range(31));
    return (r == REG_A7) ? 5'd1 : r;
  endfunction

  function automatic logic [4:0] pick_rs();
    return ($urandom_range(3) == 0) ? 5'($urandom_range(31)) : 5'($urandom_range(15));
  endfunction

  function automatic logic [31:0] random_instr();
    logic [31:0] w;
    logic [12:0] bo;
    logic [20:0] jo;
    logic [11:0] imm;
    logic [6:0]  f7;
    logic [2:0]  f3;
    int          off;
    w = $urandom;
    f3 = 3'($urandom_range(7));
    imm = 12'($urandom);
    off = (int'($urandom_range(31)) - 16) * 4;
    bo = 13'(off);
    jo = ($urandom_range(7) == 0) ? 21'($urandom) : 21'(off);
    case ($urandom_range(13))
      0, 1: begin
        case ($urandom_range(3))
          0, 1: f7 = F7_BASE;
          2: f7 = F7_ALT;
          default: f7 = 7'($urandom);
        endcase
        w = {f7, pick_rs(), pick_rs(), f3, pick_rd(), OPC_OP};
      end
      2, 3: begin
        if (f3 == F3_SLL || f3 == F3_SR)
          case ($urandom_range(3))
            0, 1: imm[11:6] = F6_BASE;
            2: imm[11:6] = F6_ALT;
            default: ;
          endcase
        w = enc_i(imm, pick_rs(), f3, pick_rd(), OPC_OPIMM);
      end
      4: w = enc_i(imm, pick_rs(), f3, pick_rd(), OPC_LOAD);
      5: w = {imm[11:5], pick_rs(), pick_rs(), 3'($urandom_range(3)), imm[4:0], OPC_STORE};
      6: w = {20'($urandom), pick_rd(), OPC_LUI};
      7: w = {20'($urandom), pick_rd(), OPC_AUIPC};
      8: w = {jo[20], jo[10:1], jo[11], jo[19:12], pick_rd(), OPC_JAL};
      9: w = enc_i(imm, pick_rs(), ($urandom_range(3) == 0) ? f3 : F3_PRIV, pick_rd(),
                   OPC_JALR);
      10, 11: w = {bo[12], bo[10:5], pick_rs(), pick_rs(), f3, bo[4:1], bo[11], OPC_BRANCH};
      12: w = enc_i('0, REG_ZERO, F3_PRIV, REG_ZERO, OPC_SYSTEM);
      default: w[11:7] = pick_rd();
    endcase
    return w;
  endfunction

  function automatic logic [15:0] pick_stack();
    case ($urandom_range(3))
      0: return 16'h0000;
      1: return 16'hffff;
      default: return 16'($urandom);
    endcase
  endfunction

  task automatic run_program(input logic [15:0] base, input int n_instr, input int n_steps);
    for (int i = 0; i < n_instr; i++) load_word(base + 16'(4 * i), random_instr());
    write_cfg(CFG_STACK, pick_stack());
    write_cfg(CFG_ENTRY, base);
    run_steps(n_steps);
  endtask

  task automatic test_directed();
    logic [15:0] base;
    base = 16'hfffe;
    run_steps(1);  // memory still cleared: no-op
    write_cfg(CFG_STACK, 16'hffff);
    load_word(base,           enc_i(12'h800, REG_SP, F3_ADDSUB, 5'd5, OPC_OPIMM));
    load_word(base + 16'd4,   enc_i(12'h001, 5'd5, F3_ADDSUB, REG_ZERO, OPC_OPIMM));
    load_word(base + 16'd8,   {20'h80000, 5'd6, OPC_LUI});
    load_word(base + 16'd12,  enc_i({F6_ALT, 6'd63}, 5'd6, F3_SR, 5'd7, OPC_OPIMM));
    load_word(base + 16'd16,  enc_i('0, REG_ZERO, F3_PRIV, REG_ZERO, OPC_SYSTEM));
    load_word(base + 16'd20,  enc_i(12'h000, 5'd7, F3_D, 5'd8, OPC_LOAD));  // ld: no-op
    write_cfg(CFG_ENTRY, base);
    run_steps(6);
    write_cfg(CFG_ENTRY, 16'h0000);
  endtask

  task automatic test_random_programs(input int s_pct, input int r_pct, input int n_prog);
    send_idle_pct = s_pct;
    recv_idle_pct = r_pct;
    for (int p = 0; p < n_prog; p++)
      run_program(($urandom_range(3) == 0) ? 16'hffff : 16'($urandom),
                  $urandom_range(10, 16), $urandom_range(16, 26));
  endtask

  // long receiver hold while the sender keeps offering
  task automatic test_backpressure();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    for (int i = 0; i < 12; i++) load_word(16'h4000 + 16'(4 * i), random_instr());
    write_cfg(CFG_ENTRY, 16'h4000);
    @(posedge clk);
    recv_hold <= 300;
    run_steps(24);
    drain_core();
  endtask

  task automatic test_halt();
    load_word(16'h0100, enc_i(12'($urandom_range(93, 94)), REG_ZERO, F3_ADDSUB, REG_A7,
                              OPC_OPIMM));
    load_word(16'h0104, enc_i('0, REG_ZERO, F3_PRIV, REG_ZERO, OPC_SYSTEM));
    write_cfg(CFG_ENTRY, 16'h0100);
    run_steps(3);
    send_item(ITEM_WRITE, 16'h0108, 8'h13);  // loader still writes while halted
    run_steps(1);
  endtask

  initial begin
    repeat (12) @(posedge clk);
    rst_n <= 1'b1;
    for (int i = 0; i < 32; i++) gpr_copy[i] = '0;
    gpr_copy[REG_SP] = {48'b0, STACK_RESET};
    pc_copy = ENTRY_RESET;
    for (int i = 0; i < 65536; i++) mem_copy[i] = '0;
    running_copy = 1'b1;
    test_directed();
    test_random_programs(25, 45, 2);
    test_random_programs(45, 25, 2);
    test_random_programs(0, 0, 2);
    test_backpressure();
    test_halt();
    drain_core();
    repeat (20) @(posedge clk);
    if (n_errors == 0 && pending_results.size() == 0) begin
      $display("Testbench completed without errors");
    end else begin
      $display("Testbench completed WITH ERRORS");
    end
    $finish;
  end

endmodule

>>> files.f
rtl/rvcore_pkg.sv
rtl/rvcore_ram.sv
rtl/rvcore_front.sv
rtl/rvcore_back.sv
rtl/rv64i_subset_core_step.sv
bench/tb_rv64i_subset_core_step.sv
